// ===== hw/rtl/triangle_mesh_hit_test_defines.svh =====
// Assertion macros shared by the hit test RTL.
`ifndef TRIANGLE_MESH_HIT_TEST_DEFINES_SVH
`define TRIANGLE_MESH_HIT_TEST_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TMHT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define TMHT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tmht_pkg.sv =====
// Types and constants of the triangle mesh hit test.
package tmht_pkg;
	localparam int unsigned FRACTION_BITS_DEF = 16;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned PROD_W  = 2 * COORD_W;
	localparam int unsigned DIFF_W  = COORD_W + 1;
	localparam int unsigned SPLIT_W = 16;
	localparam int unsigned HALF_W  = DIFF_W - SPLIT_W;
	localparam int unsigned PART_W  = DIFF_W + HALF_W;
	localparam int unsigned ACC_W   = 2 * DIFF_W + 2;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned QDEPTH  = 2;
	localparam logic signed [COORD_W-1:0] ONE_Q = 32'sh0001_0000;

	typedef enum logic [2:0] {
		REG_M11 = 3'd0,
		REG_M12 = 3'd1,
		REG_M13 = 3'd2,
		REG_M21 = 3'd3,
		REG_M22 = 3'd4,
		REG_M23 = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] m11;
		logic signed [COORD_W-1:0] m12;
		logic signed [COORD_W-1:0] m13;
		logic signed [COORD_W-1:0] m21;
		logic signed [COORD_W-1:0] m22;
		logic signed [COORD_W-1:0] m23;
	} matrix_t;

	// transformed triangle plus query, front to back
	typedef struct packed {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] x0;
		logic signed [COORD_W-1:0] y0;
		logic signed [COORD_W-1:0] x1;
		logic signed [COORD_W-1:0] y1;
		logic signed [COORD_W-1:0] x2;
		logic signed [COORD_W-1:0] y2;
		logic                      use_parity;
		logic                      last_tri;
	} entry_t;
endpackage

// ===== hw/rtl/tmht_if.sv =====
// Stream interfaces of the hit test: query items in, results out.
interface tmht_in_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] px;
	logic signed [31:0] py;
	logic signed [31:0] ax;
	logic signed [31:0] ay;
	logic signed [31:0] bx;
	logic signed [31:0] by_;
	logic signed [31:0] cx;
	logic signed [31:0] cy;
	logic        use_parity;
	logic        last_tri;
	modport source(output valid, px, py, ax, ay, bx, by_, cx, cy, use_parity, last_tri,
		input ready);
	modport sink(input valid, px, py, ax, ay, bx, by_, cx, cy, use_parity, last_tri,
		output ready);
endinterface

interface tmht_out_if;
	logic valid;
	logic ready;
	logic inside_res;
	modport source(output valid, inside_res, input ready);
	modport sink(input valid, inside_res, output ready);
endinterface

// ===== hw/rtl/tmht_front.sv =====
// Front end: takes an item and maps its three vertices through the matrix.
module tmht_front #(
	parameter int unsigned FRACTION_BITS = tmht_pkg::FRACTION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	tmht_in_if.sink           item,
	input  tmht_pkg::matrix_t mat,
	output tmht_pkg::entry_t  push_data,
	output logic              push_valid,
	input  logic              push_ready
);
	localparam logic [3:0] N_PROD = 4'd12;
	localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
	localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_CALC = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t st_q;
	logic [3:0] cnt_q;
	logic [3:0] pidx_q;
	logic signed [31:0] px_q, py_q;
	logic signed [31:0] raw_q [6];
	logic use_q, last_q;
	logic signed [31:0] tx_q [3];
	logic signed [31:0] ty_q [3];
	logic signed [63:0] prod_q;
	logic signed [64:0] sum_q;

	logic signed [31:0] coef, rawv, kt;
	logic signed [63:0] mul;
	logic signed [64:0] tot, shifted;
	logic signed [65:0] res;
	logic signed [31:0] sat;

	// product n: vertex n[3:2], row n[1] (x or y), term n[0]
	always_comb begin
		if (cnt_q[1]) coef = cnt_q[0] ? mat.m22 : mat.m21;
		else          coef = cnt_q[0] ? mat.m12 : mat.m11;
		rawv = raw_q[{cnt_q[3:2], cnt_q[0]}];
		mul  = coef * rawv;
		kt   = pidx_q[1] ? mat.m23 : mat.m13;
		tot     = sum_q + {prod_q[63], prod_q};
		shifted = tot >>> FRACTION_BITS;
		res     = {shifted[64], shifted} + {{34{kt[31]}}, kt};
		if (res > SAT_HI)      sat = 32'sh7FFF_FFFF;
		else if (res < SAT_LO) sat = 32'sh8000_0000;
		else                   sat = res[31:0];
	end

	assign item.ready = (st_q == F_IDLE);
	assign push_valid = (st_q == F_PUSH);

	always_comb begin
		push_data = '0;
		push_data.px = px_q;
		push_data.py = py_q;
		push_data.x0 = tx_q[0];
		push_data.y0 = ty_q[0];
		push_data.x1 = tx_q[1];
		push_data.y1 = ty_q[1];
		push_data.x2 = tx_q[2];
		push_data.y2 = ty_q[2];
		push_data.use_parity = use_q;
		push_data.last_tri = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= F_IDLE;
			cnt_q <= '0;
		end else begin
			case (st_q)
				F_IDLE: begin
					if (item.valid) begin
						st_q  <= F_CALC;
						cnt_q <= '0;
					end
				end
				F_CALC: begin
					if (cnt_q == N_PROD) st_q <= F_PUSH;
					cnt_q <= cnt_q + 4'd1;
				end
				F_PUSH: begin
					if (push_ready) st_q <= F_IDLE;
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == F_IDLE && item.valid) begin
			px_q     <= item.px;
			py_q     <= item.py;
			raw_q[0] <= item.ax;
			raw_q[1] <= item.ay;
			raw_q[2] <= item.bx;
			raw_q[3] <= item.by_;
			raw_q[4] <= item.cx;
			raw_q[5] <= item.cy;
			use_q    <= item.use_parity;
			last_q   <= item.last_tri;
		end
		if (st_q == F_CALC) begin
			if (cnt_q != N_PROD) begin
				prod_q <= mul;
				pidx_q <= cnt_q;
			end
			if (cnt_q != 4'd0) begin
				if (!pidx_q[0]) sum_q <= {prod_q[63], prod_q};
				else if (pidx_q[1]) ty_q[pidx_q[3:2]] <= sat;
				else tx_q[pidx_q[3:2]] <= sat;
			end
		end
	end
endmodule

// ===== hw/rtl/tmht_queue.sv =====
// Short queue between front and back end.
module tmht_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  tmht_pkg::entry_t push_data,
	output logic             pop_valid,
	input  logic             pop,
	output tmht_pkg::entry_t pop_data
);
	localparam int unsigned PTR_W = $clog2(tmht_pkg::QDEPTH);

	tmht_pkg::entry_t mem_q [tmht_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;
	logic do_push, do_pop;

	assign push_ready = (cnt_q != (PTR_W+1)'(tmht_pkg::QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PTR_W'(tmht_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == PTR_W'(tmht_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end
endmodule

// ===== hw/rtl/tmht_back.sv =====
// Back end: exact sign tests on one shared multiplier, accumulators, result register.
`include "triangle_mesh_hit_test_defines.svh"
module tmht_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tmht_pkg::entry_t head,
	input  logic             head_valid,
	output logic             pop,
	tmht_out_if.source       result
);
	localparam int unsigned DW = tmht_pkg::DIFF_W;
	localparam int unsigned AW = tmht_pkg::ACC_W;
	localparam int unsigned SW = tmht_pkg::SPLIT_W;
	localparam logic [2:0] ST_LOAD    = 3'd0;
	localparam logic [2:0] ST_DONE    = 3'd6;
	localparam logic [2:0] FIRST_EDGE = 3'd3;
	localparam logic [2:0] LAST_OP    = 3'd5;

	logic busy_q;
	logic [2:0] k_q, st_q;
	logic signed [DW-1:0] a_q, b_q, c_q, d_q;
	logic edge_ok_q;
	logic signed [tmht_pkg::PART_W-1:0] prod_q;
	logic shift_q, sub_q;
	logic signed [AW-1:0] acc_q;
	logic neg_q, pos_q, parity_q, hit_q;
	logic out_valid_q, inside_q;

	logic signed [31:0] tx [3];
	logic signed [31:0] ty [3];
	logic [1:0] ei, ej;
	logic signed [31:0] xi, yi, xj, yj, x1, y1, x2, y2, px, py;
	logic signed [DW-1:0] na, nb, nc, nd;
	logic n_ok, swap;
	logic sel_c, hi;
	logic signed [DW-1:0] m_a, m_b;
	logic signed [tmht_pkg::HALF_W-1:0] half;
	logic signed [tmht_pkg::PART_W-1:0] mul;
	logic signed [AW-1:0] term;
	logic neg, pos, flip, par_n, hit_n, can_finish;

	assign tx[0] = head.x0;
	assign tx[1] = head.x1;
	assign tx[2] = head.x2;
	assign ty[0] = head.y0;
	assign ty[1] = head.y1;
	assign ty[2] = head.y2;
	assign px = head.px;
	assign py = head.py;

	// operand selection for op k: crosses 0..2, edges 3..5
	always_comb begin
		ei = (k_q >= FIRST_EDGE) ? 2'(k_q - FIRST_EDGE) : k_q[1:0];
		ej = (ei == 2'd2) ? 2'd0 : ei + 2'd1;
		xi = tx[ei];
		yi = ty[ei];
		xj = tx[ej];
		yj = ty[ej];
		swap = (yi > yj);
		x1 = swap ? xj : xi;
		y1 = swap ? yj : yi;
		x2 = swap ? xi : xj;
		y2 = swap ? yi : yj;
		if (k_q < FIRST_EDGE) begin
			na = {px[31], px} - {xi[31], xi};
			nb = {py[31], py} - {yj[31], yj};
			nc = {py[31], py} - {yi[31], yi};
			nd = {px[31], px} - {xj[31], xj};
			n_ok = 1'b0;
		end else begin
			na = {x2[31], x2} - {x1[31], x1};
			nb = {py[31], py} - {y1[31], y1};
			nc = {px[31], px} - {x1[31], x1};
			nd = {y2[31], y2} - {y1[31], y1};
			n_ok = (yi != yj) && (py > y1) && (py <= y2);
		end
	end

	// steps 1..4 issue a*b lo/hi, c*d lo/hi; steps 2..5 accumulate
	always_comb begin
		sel_c = (st_q == 3'd3) || (st_q == 3'd4);
		hi    = (st_q == 3'd2) || (st_q == 3'd4);
		m_a   = sel_c ? c_q : a_q;
		m_b   = sel_c ? d_q : b_q;
		half  = hi ? m_b[DW-1:SW] : {1'b0, m_b[SW-1:0]};
		mul   = m_a * half;
		term  = shift_q ? (AW'(prod_q) <<< SW) : AW'(prod_q);
	end

	assign neg   = acc_q[AW-1];
	assign pos   = !neg && (acc_q != '0);
	assign flip  = edge_ok_q && pos;
	assign par_n = parity_q ^ flip;
	assign hit_n = hit_q | !(neg_q && pos_q);
	assign can_finish = !head.last_tri || !out_valid_q || result.ready;
	assign pop = busy_q && (k_q == LAST_OP) && (st_q == ST_DONE) && can_finish;

	assign result.valid      = out_valid_q;
	assign result.inside_res = inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			k_q         <= '0;
			st_q        <= ST_LOAD;
			neg_q       <= 1'b0;
			pos_q       <= 1'b0;
			parity_q    <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && result.ready) out_valid_q <= 1'b0;
			if (!busy_q) begin
				if (head_valid) begin
					busy_q <= 1'b1;
					k_q    <= '0;
					st_q   <= ST_LOAD;
					neg_q  <= 1'b0;
					pos_q  <= 1'b0;
				end
			end else if (st_q != ST_DONE) begin
				st_q <= st_q + 3'd1;
			end else if (k_q < FIRST_EDGE) begin
				neg_q <= neg_q | neg;
				pos_q <= pos_q | pos;
				k_q   <= k_q + 3'd1;
				st_q  <= ST_LOAD;
			end else if (k_q != LAST_OP) begin
				parity_q <= par_n;
				k_q      <= k_q + 3'd1;
				st_q     <= ST_LOAD;
			end else if (can_finish) begin
				busy_q <= 1'b0;
				if (head.last_tri) begin
					out_valid_q <= 1'b1;
					parity_q    <= 1'b0;
					hit_q       <= 1'b0;
				end else begin
					parity_q <= par_n;
					hit_q    <= hit_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && st_q == ST_LOAD) begin
			a_q       <= na;
			b_q       <= nb;
			c_q       <= nc;
			d_q       <= nd;
			edge_ok_q <= n_ok;
			acc_q     <= '0;
		end
		if (busy_q && st_q >= 3'd1 && st_q <= 3'd4) begin
			prod_q  <= mul;
			shift_q <= hi;
			sub_q   <= sel_c;
		end
		if (busy_q && st_q >= 3'd2 && st_q <= 3'd5)
			acc_q <= sub_q ? acc_q - term : acc_q + term;
		if (pop && head.last_tri)
			inside_q <= head.use_parity ? par_n : hit_n;
	end

	`TMHT_ASSERT_IMP(a_pop_busy, pop, busy_q && head_valid, "pop without a held entry")
	`TMHT_ASSERT_NXT(a_pop_free, pop, !busy_q, "still busy after finishing an item")
	`TMHT_ASSERT_IMP(a_seq_range, busy_q, k_q <= LAST_OP && st_q <= ST_DONE, "sequencer out of range")
	`TMHT_ASSERT_NXT(a_emit, pop && head.last_tri, out_valid_q, "last triangle gave no result")
endmodule

// ===== hw/rtl/triangle_mesh_hit_test.sv =====
// Top level of the triangle mesh hit test: register file, front, queue, back.
//
// item:   one beat per triangle, carrying the query point, the three raw
//         vertices, the mode and the last-triangle flag. ready is high while
//         the front end is free.
// result: one beat with inside_res on the last triangle of each query.
// APB:    six Q16.16 matrix registers m11..m23 at byte offsets 0..20, reads
//         return the register, pready always high. Write only while idle.
// Flow:   the front transforms a triangle after its beat on one 32x32
//         multiplier (12 products), hands it over when the queue has room
//         and only then takes a new beat. The back picks up the queue
//         head and runs six exact sign tests on one 33x17 multiplier,
//         each through load, multiply, accumulate and done steps; the
//         entry is popped after the last test. The result is registered
//         when the back finishes the last triangle of a query.
// A 2-entry queue lets the front take the next triangle while the back works.
// Reset loads the identity matrix, clears the accumulators and empties the
// queue. A stalled result holds in its register; the back keeps working and
// only waits when the next result is due while the previous one still holds.
module triangle_mesh_hit_test #(
	parameter int unsigned FRACTION_BITS = tmht_pkg::FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tmht_in_if.sink                     item,
	tmht_out_if.source                  result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tmht_pkg::ADDR_W-1:0] paddr,
	input  logic [tmht_pkg::DATA_W-1:0] pwdata,
	output logic [tmht_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	tmht_pkg::matrix_t mat_q;
	tmht_pkg::reg_idx_t ridx;
	tmht_pkg::entry_t push_data, head;
	logic push_valid, push_ready, head_valid, pop;

	assign pready = 1'b1;
	assign ridx   = tmht_pkg::reg_idx_t'(paddr[tmht_pkg::ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q.m11 <= tmht_pkg::ONE_Q;
			mat_q.m12 <= '0;
			mat_q.m13 <= '0;
			mat_q.m21 <= '0;
			mat_q.m22 <= tmht_pkg::ONE_Q;
			mat_q.m23 <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				tmht_pkg::REG_M11: mat_q.m11 <= pwdata;
				tmht_pkg::REG_M12: mat_q.m12 <= pwdata;
				tmht_pkg::REG_M13: mat_q.m13 <= pwdata;
				tmht_pkg::REG_M21: mat_q.m21 <= pwdata;
				tmht_pkg::REG_M22: mat_q.m22 <= pwdata;
				tmht_pkg::REG_M23: mat_q.m23 <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			tmht_pkg::REG_M11: prdata = mat_q.m11;
			tmht_pkg::REG_M12: prdata = mat_q.m12;
			tmht_pkg::REG_M13: prdata = mat_q.m13;
			tmht_pkg::REG_M21: prdata = mat_q.m21;
			tmht_pkg::REG_M22: prdata = mat_q.m22;
			tmht_pkg::REG_M23: prdata = mat_q.m23;
			default:           prdata = '0;
		endcase
	end

	tmht_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.mat        (mat_q),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	tmht_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (head_valid),
		.pop        (pop),
		.pop_data   (head)
	);

	tmht_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.result     (result)
	);
endmodule

// ===== bench/triangle_mesh_hit_test_tb.sv =====
// Self-checking testbench for the triangle mesh hit test: random and directed queries.
`timescale 1ns / 100ps

module triangle_mesh_hit_test_tb;
	import tmht_pkg::*;

	localparam int FB = FRACTION_BITS_DEF;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 120;

	typedef struct {
		logic signed [31:0] px, py, ax, ay, bx, by_, cx, cy;
		logic use_parity, last_tri;
	} tri_beat_t;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;

	tmht_in_if item_bus();
	tmht_out_if res_bus();

	triangle_mesh_hit_test i_dut (
		.clk(clk), .arst_n(arst_n), .item(item_bus), .result(res_bus),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	tri_beat_t pending_tris[$];
	logic expected_inside[$];
	logic signed [31:0] mat [6];
	logic parity_acc, hit_acc;
	int errors, quiet_cycles;
	bit calm;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// affine map of one coordinate: floor of exact sum, translate, saturate
	function automatic logic signed [31:0] map_coord(logic signed [31:0] ka, kb, kt, u, v);
		logic signed [127:0] s;
		s = 128'(ka) * 128'(u) + 128'(kb) * 128'(v);
		s = (s >>> FB) + 128'(kt);
		if (s > 128'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (s < -128'sh8000_0000) return 32'sh8000_0000;
		return s[31:0];
	endfunction

	// sign of a*b - c*d, exact
	function automatic int sign_of_diff(logic signed [127:0] a, b, c, d);
		logic signed [127:0] r;
		r = a * b - c * d;
		return (r < 0) ? -1 : (r == 0) ? 0 : 1;
	endfunction

	// updates accumulators; returns 1 with the verdict when the query closes
	function automatic bit hit_test_step(tri_beat_t t, output logic verdict);
		logic signed [127:0] vx[3], vy[3], px, py, x1, y1, x2, y2, tmp;
		logic signed [31:0] rx[3], ry[3];
		bit neg, pos;
		int d, j;
		rx = '{t.ax, t.bx, t.cx};
		ry = '{t.ay, t.by_, t.cy};
		px = 128'(t.px);
		py = 128'(t.py);
		neg = 0;
		pos = 0;
		for (int i = 0; i < 3; i++) begin
			vx[i] = 128'(map_coord(mat[REG_M11], mat[REG_M12], mat[REG_M13], rx[i], ry[i]));
			vy[i] = 128'(map_coord(mat[REG_M21], mat[REG_M22], mat[REG_M23], rx[i], ry[i]));
		end
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			d = sign_of_diff(px - vx[i], py - vy[j], py - vy[i], px - vx[j]);
			if (d < 0) neg = 1;
			if (d > 0) pos = 1;
		end
		if (!(neg && pos)) hit_acc = 1;
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			x1 = vx[i]; y1 = vy[i]; x2 = vx[j]; y2 = vy[j];
			if (y1 != y2) begin
				if (y1 > y2) begin
					tmp = x1; x1 = x2; x2 = tmp;
					tmp = y1; y1 = y2; y2 = tmp;
				end
				if (py > y1 && py <= y2 && sign_of_diff(x2 - x1, py - y1, px - x1, y2 - y1) > 0)
					parity_acc ^= 1'b1;
			end
		end
		verdict = t.use_parity ? parity_acc : hit_acc;
		if (!t.last_tri) return 0;
		parity_acc = 0;
		hit_acc = 0;
		return 1;
	endfunction

	// driver: presents the queue head, idles at random; a waiting beat holds
	always @(posedge clk) begin
		logic verdict;
		logic show;
		if (item_bus.valid && item_bus.ready) begin
			if (hit_test_step(pending_tris[0], verdict)) expected_inside.push_back(verdict);
			void'(pending_tris.pop_front());
		end
		show = pending_tris.size() > 0 &&
			((item_bus.valid && !item_bus.ready) || calm || $urandom_range(0, 99) >= 21);
		item_bus.valid <= show;
		if (show) begin
			item_bus.px <= pending_tris[0].px;
			item_bus.py <= pending_tris[0].py;
			item_bus.ax <= pending_tris[0].ax;
			item_bus.ay <= pending_tris[0].ay;
			item_bus.bx <= pending_tris[0].bx;
			item_bus.by_ <= pending_tris[0].by_;
			item_bus.cx <= pending_tris[0].cx;
			item_bus.cy <= pending_tris[0].cy;
			item_bus.use_parity <= pending_tris[0].use_parity;
			item_bus.last_tri <= pending_tris[0].last_tri;
		end
	end

	// monitor: result beats against the oldest verdict
	always @(posedge clk) begin
		if (res_bus.valid && res_bus.ready) begin
			if (expected_inside.size() == 0) begin
				$error("inside_res: unexpected beat, actual %0b", res_bus.inside_res);
				errors++;
			end else begin
				if (res_bus.inside_res !== expected_inside[0]) begin
					$error("inside_res: expected %0b actual %0b", expected_inside[0],
						res_bus.inside_res);
					errors++;
				end
				void'(expected_inside.pop_front());
			end
		end
		res_bus.ready <= calm || $urandom_range(0, 99) >= 21;
	end

	// watchdog
	always @(posedge clk) begin
		if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic signed [31:0] value);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ADDR_W'(4 * int'(idx)); pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		mat[idx] = value;
	endtask

	task automatic load_matrix(logic signed [31:0] a, b, c, d, e, f);
		write_reg(REG_M11, a); write_reg(REG_M12, b); write_reg(REG_M13, c);
		write_reg(REG_M21, d); write_reg(REG_M22, e); write_reg(REG_M23, f);
	endtask

	task automatic settle();
		wait (pending_tris.size() == 0 && expected_inside.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			2: return 32'($signed($urandom_range(0, 16)) - 8) <<< FB;
			default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
		endcase
	endfunction

	function automatic void queue_tri(logic signed [31:0] px, py, ax, ay, bx, by_, cx, cy,
		logic up, lt);
		pending_tris.push_back('{px, py, ax, ay, bx, by_, cx, cy, up, lt});
	endfunction

	task automatic queue_queries(int count);
		logic signed [31:0] px, py;
		logic up;
		int n;
		while (count > 0) begin
			px = rand_coord(); py = rand_coord(); up = $urandom_range(0, 1);
			n = $urandom_range(1, 6);
			for (int k = 0; k < n && count > 0; k++) begin
				// occasional broken query: point or mode moves mid-stream
				if ($urandom_range(0, 19) == 0) begin
					px = rand_coord(); up = $urandom_range(0, 1);
				end
				queue_tri(px, py, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), up, k == n - 1 || count == 1);
				count--;
			end
		end
	endtask

	initial begin
		localparam logic signed [31:0] U = ONE_Q;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		item_bus.valid = 0; item_bus.px = 0; item_bus.py = 0; item_bus.ax = 0;
		item_bus.ay = 0; item_bus.bx = 0; item_bus.by_ = 0; item_bus.cx = 0;
		item_bus.cy = 0; item_bus.use_parity = 0; item_bus.last_tri = 0;
		res_bus.ready = 0;
		mat = '{U, 0, 0, 0, U, 0};
		parity_acc = 0; hit_acc = 0; errors = 0; quiet_cycles = 0; calm = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed, identity matrix
		queue_tri(U, U, 0, 0, 4*U, 0, 0, 4*U, 0, 1);           // strictly inside
		queue_tri(2*U, 0, 0, 0, 4*U, 0, 0, 4*U, 0, 1);         // on an edge
		queue_tri(0, 0, 0, 0, 4*U, 0, 0, 4*U, 0, 1);           // on a vertex
		queue_tri(9*U, 9*U, 0, 0, 4*U, 0, 0, 4*U, 0, 1);       // outside
		queue_tri(U, U, 0, 0, 2*U, 2*U, 4*U, 4*U, 0, 1);       // degenerate through point
		queue_tri(5*U, U, 0, 0, 2*U, 2*U, 4*U, 4*U, 0, 1);     // degenerate, off point
		queue_tri(U, U, 0, 0, 4*U, 0, 0, 4*U, 1, 1);           // parity, inside
		queue_tri(-U, 0, 0, 0, 4*U, 0, 0, 4*U, 1, 1);          // ray along horizontal edge
		queue_tri(-U, 4*U, 0, 0, 4*U, 0, 0, 4*U, 1, 1);        // ray through apex
		queue_tri(U, U, 0, 0, 4*U, 0, 0, 4*U, 1, 0);           // two overlapping triangles
		queue_tri(U, U, 0, 0, 4*U, 0, 0, 4*U, 1, 1);
		queue_tri(U, U, 0, 0, 4*U, 0, 0, 4*U, 0, 0);           // mode changes mid-query
		queue_tri(U, U, 9*U, 9*U, 8*U, 9*U, 9*U, 8*U, 1, 1);
		queue_tri(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 1);
		queue_tri(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1, 1);
		queue_tri(-1, -1, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 1, 1);
		queue_queries(240);
		settle();

		load_matrix(2*U, 0, 3*U, 0, 2*U, -3*U);
		queue_queries(250);
		calm = 1;
		queue_queries(120);
		wait (pending_tris.size() == 0);
		calm = 0;
		settle();

		load_matrix(0, -U, U, U, 0, -U);
		queue_queries(250);
		settle();

		load_matrix(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
		queue_queries(150);
		settle();

		load_matrix($urandom_range(0, 4*U) - 2*U, $urandom_range(0, U) - U/2, $urandom,
			$urandom_range(0, U) - U/2, $urandom_range(0, 4*U) - 2*U, $urandom);
		queue_queries(250);
		settle();

		load_matrix(U, 0, 0, 0, U, 0);
		queue_queries(270);
		settle();

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
